[hw/rtl/rgbct_pkg.sv]
// Shared types and constants for the RGB color temperature pipeline.
`timescale 1ns / 1ps

package rgbct_pkg;

  localparam int FRAC_BITS = 16;

  localparam int CNT_W    = 16;
  localparam int X_W      = 23;
  localparam int RECIP_SH = 40;
  localparam int RECIP_W  = 31;
  localparam int FS_W     = 16;
  localparam int PCT_W    = 13;
  localparam int COEF_W   = 19;
  localparam int PROD_W   = 33;
  localparam int XYZ_W    = 36;
  localparam int NUM_W    = 52;
  localparam int REM_W    = 56;
  localparam int NM_W     = FRAC_BITS + 4;
  localparam int N2_W     = FRAC_BITS + 8;
  localparam int N3_W     = FRAC_BITS + 12;
  localparam int A3_W     = FRAC_BITS + 6;
  localparam int K10      = FRAC_BITS + 10;
  localparam int M10_W    = FRAC_BITS + 8;
  localparam int Q10_W    = FRAC_BITS + 6;
  localparam int T_W      = FRAC_BITS + 18;
  localparam int CT_W     = FRAC_BITS + 24;
  localparam int OUT_W    = 15;
  localparam int DIV_STEPS = NM_W;

  localparam logic [7:0] ITIME_2P4  = 8'd255;
  localparam logic [7:0] ITIME_24   = 8'd246;
  localparam logic [7:0] ITIME_101  = 8'd213;
  localparam logic [7:0] ITIME_154  = 8'd192;
  localparam logic [7:0] ITIME_700  = 8'd0;

  localparam logic [FS_W-1:0] FS_1024  = 16'd1024;
  localparam logic [FS_W-1:0] FS_10240 = 16'd10240;
  localparam logic [FS_W-1:0] FS_43008 = 16'd43008;
  localparam logic [FS_W-1:0] FS_65535 = 16'd65535;

  localparam longint unsigned RCP_1024  = (64'd1 << RECIP_SH) / 64'd1024;
  localparam longint unsigned RCP_10240 = (64'd1 << RECIP_SH) / 64'd10240;
  localparam longint unsigned RCP_43008 = (64'd1 << RECIP_SH) / 64'd43008;
  localparam longint unsigned RCP_65535 = (64'd1 << RECIP_SH) / 64'd65535;

  localparam longint unsigned M10    = (64'd1 << K10) / 64'd10;
  localparam longint unsigned CT_OFS = ((64'd552033 << FRAC_BITS) + 64'd50) / 64'd100;
  localparam longint unsigned CT_MAX = 64'd12000 << FRAC_BITS;

  localparam logic signed [COEF_W-1:0] XYZ_COEF [3][3] = '{
    '{-19'sd14282, 19'sd154924, -19'sd95641},
    '{-19'sd32466, 19'sd157837, -19'sd73191},
    '{-19'sd68202, 19'sd77073,  19'sd56332}
  };

  typedef struct packed {
    logic [CNT_W-1:0] red_count;
    logic [CNT_W-1:0] green_count;
    logic [CNT_W-1:0] blue_count;
  } rgbct_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] color_temp;
    logic                    invalid;
  } rgbct_out_t;

  typedef struct packed {
    logic kill;
    logic inv;
  } rgbct_ctl_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [REM_W-1:0] ud8;
    logic [NM_W-1:0]  q;
    logic             sgn;
    rgbct_ctl_t       ctl;
  } rgbct_div_t;

endpackage

[hw/rtl/rgb_color_temperature.sv]
// Top level: pipelined correlated color temperature from one RGB reading.
//
// Input channel: in_valid / in_stall carrying in_data (red, green, blue counts).
// A request is taken at a clock edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall carrying out_data (color_temp, invalid).
// Config channel: cfg_valid / cfg_ready with cfg_data, the integration time
// register; cfg_ready is always high. Write it only while the pipe is empty.
// The pipe runs through the percent divide, matrix, one-bit-per-stage quotient
// divider and cubic stages.
// Throughput: one request per cycle while the receiver does not stall.
// When out_stall holds a waiting result, the whole pipe freezes and in_stall
// rises; nothing is lost or repeated.
// Reset (rst_n low, synchronous) empties the pipe and sets the integration
// time register to 255.
// A result of -1 (all ones) means out of range; invalid flags an unlisted
// timing value or a zero denominator.
`timescale 1ns / 1ps

module rgb_color_temperature (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  rgbct_pkg::rgbct_in_t in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rgbct_pkg::rgbct_out_t out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [7:0]           cfg_data
);
  import rgbct_pkg::*;

  localparam int NV = 7 + DIV_STEPS + 1 + 4 + 1;
  localparam int QE_W_C = PCT_W;

  logic          en;
  logic [NV-1:0] vld_r;
  logic [7:0]    itime_r;

  // stage 1
  logic [X_W-1:0]     x_r   [3];
  logic [FS_W-1:0]    fs1_r;
  logic [RECIP_W-1:0] rcp_r;
  rgbct_ctl_t         ctl1_r;
  // stage 2
  logic [X_W-1:0]     x2_r  [3];
  logic [QE_W_C-1:0]  qe_r  [3];
  logic [FS_W-1:0]    fs2_r;
  rgbct_ctl_t         ctl2_r;
  // stage 3
  logic [PCT_W-1:0]   pct_r [3];
  rgbct_ctl_t         ctl3_r;
  // stage 4
  logic signed [PROD_W-1:0] prod_r [3][3];
  rgbct_ctl_t         ctl4_r;
  // stage 5
  logic signed [XYZ_W-1:0] xyz_r [3];
  rgbct_ctl_t         ctl5_r;
  // stage 6
  logic signed [XYZ_W-1:0] x6_r, y6_r, s_r;
  rgbct_ctl_t         ctl6_r;
  // stage 7
  logic signed [NUM_W-1:0] num_r, den_r;
  rgbct_ctl_t         ctl7_r;
  // divider
  rgbct_div_t         div_r [DIV_STEPS+1];
  // cubic stages
  logic [NM_W-1:0]    nma_r, nmb_r;
  logic [N2_W-1:0]    n2a_r, n2b_r, n2c_r;
  logic [A3_W-1:0]    a3a_r, a3b_r;
  logic [Q10_W-1:0]   q10e_r;
  logic [N3_W-1:0]    n3b_r, n3c_r;
  logic [T_W-1:0]     t_r;
  logic               sgna_r, sgnb_r, sgnc_r;
  rgbct_ctl_t         ctla_r, ctlb_r, ctlc_r, ctld_r;
  logic signed [CT_W-1:0] ct_r;
  rgbct_out_t         out_r;

  logic [CNT_W-1:0]   cnt [3];
  logic [FS_W-1:0]    fs_sel;
  logic [RECIP_W-1:0] rcp_sel;
  logic               bad_t;

  assign en        = !vld_r[NV-1] || !out_stall;
  assign in_stall  = !en;
  assign out_valid = vld_r[NV-1];
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  assign cnt[0] = in_data.red_count;
  assign cnt[1] = in_data.green_count;
  assign cnt[2] = in_data.blue_count;

  always_comb begin
    bad_t   = 1'b0;
    fs_sel  = FS_1024;
    rcp_sel = RECIP_W'(RCP_1024);
    unique case (itime_r)
      ITIME_2P4: begin
        fs_sel  = FS_1024;
        rcp_sel = RECIP_W'(RCP_1024);
      end
      ITIME_24: begin
        fs_sel  = FS_10240;
        rcp_sel = RECIP_W'(RCP_10240);
      end
      ITIME_101: begin
        fs_sel  = FS_43008;
        rcp_sel = RECIP_W'(RCP_43008);
      end
      ITIME_154, ITIME_700: begin
        fs_sel  = FS_65535;
        rcp_sel = RECIP_W'(RCP_65535);
      end
      default: bad_t = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      itime_r <= ITIME_2P4;
    end else if (cfg_valid && cfg_ready) begin
      itime_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NV-2:0], in_valid};
    end
  end

  // percent of full scale, matrix, ratio terms
  logic [X_W+RECIP_W-1:0] rprod [3];
  logic [X_W-1:0]         prem  [3];
  logic [PCT_W-1:0]       pct_nxt [3];
  logic signed [XYZ_W-1:0] xyz_nxt [3];
  logic [NUM_W-1:0]       un, ud;
  logic                   big;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rprod[c]   = (X_W+RECIP_W)'(x_r[c]) * (X_W+RECIP_W)'(rcp_r);
      prem[c]    = x2_r[c] - X_W'(qe_r[c]) * X_W'(fs2_r);
      pct_nxt[c] = qe_r[c] + PCT_W'(prem[c] >= X_W'(fs2_r));
      xyz_nxt[c] = XYZ_W'(prod_r[c][0]) + XYZ_W'(prod_r[c][1]) + XYZ_W'(prod_r[c][2]);
    end
    un  = num_r[NUM_W-1] ? NUM_W'(-num_r) : NUM_W'(num_r);
    ud  = den_r[NUM_W-1] ? NUM_W'(-den_r) : NUM_W'(den_r);
    big = {4'b0, un} >= {ud, 4'b0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        x_r[c]   <= X_W'(cnt[c]) * X_W'(100);
        x2_r[c]  <= x_r[c];
        qe_r[c]  <= PCT_W'(rprod[c] >> RECIP_SH);
        pct_r[c] <= pct_nxt[c];
        for (int j = 0; j < 3; j++) begin
          prod_r[c][j] <= PROD_W'(XYZ_COEF[c][j]) * PROD_W'($signed({1'b0, pct_r[j]}));
        end
        xyz_r[c] <= xyz_nxt[c];
      end
      fs1_r  <= fs_sel;
      rcp_r  <= rcp_sel;
      ctl1_r <= '{kill: bad_t, inv: bad_t};
      fs2_r  <= fs1_r;
      ctl2_r <= ctl1_r;
      ctl3_r <= ctl2_r;
      ctl4_r <= ctl3_r;
      ctl5_r <= ctl4_r;
      x6_r   <= xyz_r[0];
      y6_r   <= xyz_r[1];
      s_r    <= xyz_r[0] + xyz_r[1] + xyz_r[2];
      ctl6_r <= ctl5_r;
      num_r  <= NUM_W'(10000) * NUM_W'(x6_r) - NUM_W'(3320) * NUM_W'(s_r);
      den_r  <= NUM_W'(1858) * NUM_W'(s_r) - NUM_W'(10000) * NUM_W'(y6_r);
      ctl7_r.kill <= ctl6_r.kill || (s_r == '0);
      ctl7_r.inv  <= ctl6_r.inv || (s_r == '0);
      div_r[0].rem <= REM_W'(un);
      div_r[0].ud8 <= REM_W'({ud, 3'b0});
      div_r[0].q   <= '0;
      div_r[0].sgn <= num_r[NUM_W-1] ^ den_r[NUM_W-1];
      div_r[0].ctl.kill <= ctl7_r.kill || (den_r == '0) || big;
      div_r[0].ctl.inv  <= ctl7_r.inv || (den_r == '0);
    end
  end

  for (genvar i = 1; i <= DIV_STEPS; i++) begin : g_div
    logic             qbit;
    logic [REM_W-1:0] rdiff;
    assign qbit  = div_r[i-1].rem >= div_r[i-1].ud8;
    assign rdiff = qbit ? div_r[i-1].rem - div_r[i-1].ud8 : div_r[i-1].rem;
    always_ff @(posedge clk) begin
      if (en) begin
        div_r[i].rem <= {rdiff[REM_W-2:0], 1'b0};
        div_r[i].ud8 <= div_r[i-1].ud8;
        div_r[i].q   <= {div_r[i-1].q[NM_W-2:0], qbit};
        div_r[i].sgn <= div_r[i-1].sgn;
        div_r[i].ctl <= div_r[i-1].ctl;
      end
    end
  end

  // cubic in n
  logic [2*NM_W-1:0]        sq;
  logic [N2_W+NM_W-1:0]     cube;
  logic [A3_W+M10_W-1:0]    rq;
  logic [A3_W-1:0]          r10;
  logic [Q10_W-1:0]         q10;
  logic [CT_W-1:0]          cmag;
  logic signed [CT_W-1:0]   ct_nxt;
  logic                     oor;

  always_comb begin
    sq     = (2*NM_W)'(div_r[DIV_STEPS].q) * (2*NM_W)'(div_r[DIV_STEPS].q);
    cube   = (N2_W+NM_W)'(n2a_r) * (N2_W+NM_W)'(nma_r);
    rq     = (A3_W+M10_W)'(a3a_r) * (A3_W+M10_W)'(M10);
    r10    = a3b_r - A3_W'(q10e_r) * A3_W'(10);
    q10    = q10e_r + Q10_W'(r10 >= A3_W'(10));
    cmag   = CT_W'(n3c_r) * CT_W'(449) + CT_W'(t_r);
    ct_nxt = (sgnc_r ? -$signed(cmag) : $signed(cmag))
           + $signed(CT_W'(n2c_r) * CT_W'(3525)) + $signed(CT_W'(CT_OFS));
    oor    = ctld_r.kill || ct_r[CT_W-1] || (ct_r > $signed(CT_W'(CT_MAX)));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nma_r  <= div_r[DIV_STEPS].q;
      n2a_r  <= N2_W'(sq >> FRAC_BITS);
      a3a_r  <= A3_W'(div_r[DIV_STEPS].q) * A3_W'(3);
      sgna_r <= div_r[DIV_STEPS].sgn;
      ctla_r <= div_r[DIV_STEPS].ctl;
      nmb_r  <= nma_r;
      n2b_r  <= n2a_r;
      a3b_r  <= a3a_r;
      n3b_r  <= N3_W'(cube >> FRAC_BITS);
      q10e_r <= Q10_W'(rq >> K10);
      sgnb_r <= sgna_r;
      ctlb_r <= ctla_r;
      n3c_r  <= n3b_r;
      n2c_r  <= n2b_r;
      t_r    <= T_W'(nmb_r) * T_W'(6823) + T_W'(q10);
      sgnc_r <= sgnb_r;
      ctlc_r <= ctlb_r;
      ct_r   <= ct_nxt;
      ctld_r <= ctlc_r;
      out_r.color_temp <= oor ? '1 : ct_r[FRAC_BITS+OUT_W-1:FRAC_BITS];
      out_r.invalid    <= ctld_r.inv;
    end
  end

endmodule

[hw/rtl/rgbct_check.sv]
// Port-level checker for the color temperature block, bound to the top level.
`timescale 1ns / 1ps

module rgbct_check (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input rgbct_pkg::rgbct_out_t out_data
);
  import rgbct_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_inv: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.invalid |-> out_data.color_temp == '1)
    else $error("invalid result not -1");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.color_temp != '1 |->
      !out_data.color_temp[OUT_W-1] && out_data.color_temp <= 15'sd12000)
    else $error("temperature out of range");

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall not tied to blocked output");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result after reset");

endmodule

bind rgb_color_temperature rgbct_check u_rgbct_check (.*);
